// File: rtl/lca_pkg.sv
// Shared types, constants and the B3/S23 rule for the cell grid.
`timescale 1ns / 1ps
`default_nettype none
package lca_pkg;

    localparam int GRID_HEIGHT = 32;
    localparam int GRID_WIDTH  = 64;
    localparam int OP_W        = 2;
    localparam int ROW_IDX_W   = 5;
    localparam int COL_IDX_W   = 6;
    localparam int ROW_W       = $clog2(GRID_HEIGHT);
    localparam int COL_W       = $clog2(GRID_WIDTH);

    typedef enum logic [OP_W-1:0] {
        OP_TOGGLE = 2'd0,
        OP_STEP   = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef struct packed {
        logic             toggle;
        logic             step;
        logic [COL_W-1:0] wr_col;
        logic             wr_col_ok;
        logic [COL_W-1:0] rd_col;
    } t_row_ctrl;

    function automatic logic alive_next(input logic self, input logic [7:0] nb);
        logic [3:0] cnt;
        cnt = '0;
        for (int i = 0; i < 8; i++) begin
            cnt = cnt + 4'(nb[i]);
        end
        alive_next = (cnt == 4'd3) || (self && (cnt == 4'd2));
    endfunction

endpackage
`default_nettype wire

// File: rtl/life_cellular_automaton.sv
// Top level: Game of Life grid as a chain of row cells with a request pipeline.
// An accepted request is registered in r_req_vld and then in r_done, which drives o_done together with o_cell_state.
// Throughput: one request per cycle while busy is low; a generation step updates all rows at once.
// busy is high during reset and until r_run is registered high after it, low otherwise.
// Reset clears every cell to dead; the receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module life_cellular_automaton (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [lca_pkg::OP_W-1:0]          i_op,
    input  wire logic [lca_pkg::ROW_IDX_W-1:0]     i_row_index,
    input  wire logic [lca_pkg::COL_IDX_W-1:0]     i_col_index,
    output logic                                   o_done,
    output logic                                   o_cell_state
);

    logic                         r_run;
    logic                         r_req_vld;
    logic                         r_req_in;
    logic [lca_pkg::ROW_W-1:0]    r_req_row;
    logic [lca_pkg::COL_W-1:0]    r_req_col;
    logic                         r_done;
    logic                         r_cell_state;

    logic                         w_acc;
    logic                         w_inside;
    logic                         w_toggle;
    logic                         w_step;
    lca_pkg::t_row_ctrl           w_ctrl;
    logic [lca_pkg::GRID_WIDTH-1:0] w_row [lca_pkg::GRID_HEIGHT];
    logic [lca_pkg::GRID_HEIGHT-1:0] w_bit;
    logic [lca_pkg::GRID_HEIGHT-1:0] w_sel;

    assign busy  = ~r_run | ~i_rst_n;
    assign w_acc = start & ~busy;

    assign w_inside = (int'(i_row_index) < lca_pkg::GRID_HEIGHT)
                   && (int'(i_col_index) < lca_pkg::GRID_WIDTH);

    always_comb begin
        w_toggle = 1'b0;
        w_step   = 1'b0;
        unique case (lca_pkg::t_op'(i_op))
            lca_pkg::OP_TOGGLE: begin
                w_toggle = w_acc;
            end
            lca_pkg::OP_STEP: begin
                w_step = w_acc;
            end
            default: begin
                w_toggle = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctrl.toggle    = w_toggle;
        w_ctrl.step      = w_step;
        w_ctrl.wr_col    = lca_pkg::COL_W'(i_col_index);
        w_ctrl.wr_col_ok = w_inside;
        w_ctrl.rd_col    = r_req_col;
    end

    for (genvar r = 0; r < lca_pkg::GRID_HEIGHT; r++) begin : g_row
        logic [lca_pkg::GRID_WIDTH-1:0] w_up;
        logic [lca_pkg::GRID_WIDTH-1:0] w_dn;

        assign w_sel[r] = (int'(i_row_index) == r);

        if (r == 0) begin : g_top
            assign w_up = '0;
        end else begin : g_mid_up
            assign w_up = w_row[r-1];
        end
        if (r == lca_pkg::GRID_HEIGHT - 1) begin : g_bot
            assign w_dn = '0;
        end else begin : g_mid_dn
            assign w_dn = w_row[r+1];
        end

        lca_row u_row (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_sel    (w_sel[r]),
            .i_row_up (w_up),
            .i_row_dn (w_dn),
            .o_row    (w_row[r]),
            .o_bit    (w_bit[r])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_req_vld    <= 1'b0;
            r_done       <= 1'b0;
            r_req_in     <= 1'b0;
            r_req_row    <= '0;
            r_req_col    <= '0;
            r_cell_state <= 1'b0;
        end else begin
            r_run     <= 1'b1;
            r_req_vld <= w_acc;
            if (w_acc) begin
                r_req_in  <= w_inside;
                r_req_row <= lca_pkg::ROW_W'(i_row_index);
                r_req_col <= lca_pkg::COL_W'(i_col_index);
            end
            r_done       <= r_req_vld;
            r_cell_state <= r_req_in & w_bit[r_req_row];
        end
    end

    assign o_done       = r_done;
    assign o_cell_state = r_cell_state;

endmodule
`default_nettype wire

// File: rtl/lca_row.sv
// One row of the grid: holds its cells and computes their next generation.
`timescale 1ns / 1ps
`default_nettype none
module lca_row (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire lca_pkg::t_row_ctrl                 i_ctrl,
    input  wire logic                               i_sel,
    input  wire logic [lca_pkg::GRID_WIDTH-1:0]     i_row_up,
    input  wire logic [lca_pkg::GRID_WIDTH-1:0]     i_row_dn,
    output logic      [lca_pkg::GRID_WIDTH-1:0]     o_row,
    output logic                                    o_bit
);

    logic [lca_pkg::GRID_WIDTH-1:0] r_row;
    logic [lca_pkg::GRID_WIDTH-1:0] n_row;
    logic [lca_pkg::GRID_WIDTH-1:0] w_gen;
    logic [lca_pkg::GRID_WIDTH+1:0] w_up_x;
    logic [lca_pkg::GRID_WIDTH+1:0] w_own_x;
    logic [lca_pkg::GRID_WIDTH+1:0] w_dn_x;

    assign w_up_x  = {1'b0, i_row_up, 1'b0};
    assign w_own_x = {1'b0, r_row, 1'b0};
    assign w_dn_x  = {1'b0, i_row_dn, 1'b0};

    for (genvar c = 0; c < lca_pkg::GRID_WIDTH; c++) begin : g_col
        assign w_gen[c] = lca_pkg::alive_next(r_row[c],
            {w_up_x[c], w_up_x[c+1], w_up_x[c+2], w_own_x[c], w_own_x[c+2],
             w_dn_x[c], w_dn_x[c+1], w_dn_x[c+2]});
    end

    always_comb begin
        n_row = r_row;
        if (i_ctrl.step) begin
            n_row = w_gen;
        end else if (i_ctrl.toggle && i_sel && i_ctrl.wr_col_ok) begin
            n_row[i_ctrl.wr_col] = ~r_row[i_ctrl.wr_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
        end else begin
            r_row <= n_row;
        end
    end

    assign o_row = r_row;
    assign o_bit = r_row[i_ctrl.rd_col];

endmodule
`default_nettype wire

// File: rtl/lca_checker.sv
// Port-level checks on the request and result timing of the cell grid, and on repeated reads and toggles.
`timescale 1ns / 1ps
`default_nettype none
module lca_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [lca_pkg::OP_W-1:0]      i_op,
    input wire logic [lca_pkg::ROW_IDX_W-1:0] i_row_index,
    input wire logic [lca_pkg::COL_IDX_W-1:0] i_col_index,
    input wire logic                          o_done,
    input wire logic                          o_cell_state
);

    logic w_acc;
    logic w_rd;
    logic w_tg;

    assign w_acc = start && !busy;
    assign w_rd  = w_acc && (i_op != lca_pkg::OP_TOGGLE) && (i_op != lca_pkg::OP_STEP);
    assign w_tg  = w_acc && (i_op == lca_pkg::OP_TOGGLE);

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> ##1 o_done)
        else $error("request without result");

    a_done_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_acc, 2))
        else $error("result without request");

    a_read_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done) && $past(w_rd, 2) && $past(w_rd, 3)
         && $past(i_row_index, 2) == $past(i_row_index, 3)
         && $past(i_col_index, 2) == $past(i_col_index, 3))
        |-> (o_cell_state == $past(o_cell_state)))
        else $error("repeated read changed");

    a_toggle_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done) && $past(w_tg, 2) && $past(w_tg, 3)
         && $past(i_row_index, 2) == $past(i_row_index, 3)
         && $past(i_col_index, 2) == $past(i_col_index, 3))
        |-> (o_cell_state != $past(o_cell_state)))
        else $error("toggle did not flip cell");

endmodule

bind life_cellular_automaton lca_checker u_lca_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_op         (i_op),
    .i_row_index  (i_row_index),
    .i_col_index  (i_col_index),
    .o_done       (o_done),
    .o_cell_state (o_cell_state)
);
`default_nettype wire

// File: tb/tb_life_cellular_automaton.sv
// Testbench for the Game of Life grid: directed script, random bursts and single requests, checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_life_cellular_automaton;

    localparam logic [lca_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SCRIPT_LEN      = 25;

    typedef struct packed {
        logic [lca_pkg::OP_W-1:0]      op;
        logic [lca_pkg::ROW_IDX_W-1:0] row;
        logic [lca_pkg::COL_IDX_W-1:0] col;
        logic                          pinned;
        logic                          pin_state;
    } t_script_row;

    typedef struct {
        logic predicted;
        logic pinned;
        logic pin_state;
        int   seq;
    } t_cell_expect;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [lca_pkg::OP_W-1:0]      i_op;
    logic [lca_pkg::ROW_IDX_W-1:0] i_row_index;
    logic [lca_pkg::COL_IDX_W-1:0] i_col_index;
    logic                          o_done;
    logic                          o_cell_state;
    logic                          pin_check;
    logic                          pin_state;

    logic [lca_pkg::GRID_WIDTH-1:0] life_grid [lca_pkg::GRID_HEIGHT];
    t_cell_expect          cell_expect_q [$];
    int                    mismatch_count;
    int                    accepted_count;
    int                    checked_count;
    int                    steps_seen;
    int                    cycle_count;
    int                    random_sent;

    t_script_row directed_script [SCRIPT_LEN] = '{
        '{lca_pkg::OP_READ,   5'd0,  6'd0,  1'b1, 1'b0},
        '{lca_pkg::OP_READ,   5'd31, 6'd63, 1'b1, 1'b0},
        '{OP_UNUSED,          5'd31, 6'd0,  1'b1, 1'b0},
        '{lca_pkg::OP_TOGGLE, 5'd0,  6'd0,  1'b1, 1'b1},
        '{lca_pkg::OP_TOGGLE, 5'd0,  6'd0,  1'b1, 1'b0},
        '{lca_pkg::OP_TOGGLE, 5'd31, 6'd63, 1'b1, 1'b1},
        '{lca_pkg::OP_STEP,   5'd31, 6'd63, 1'b1, 1'b0},
        '{lca_pkg::OP_TOGGLE, 5'd10, 6'd20, 1'b1, 1'b1},
        '{lca_pkg::OP_TOGGLE, 5'd10, 6'd21, 1'b1, 1'b1},
        '{lca_pkg::OP_TOGGLE, 5'd10, 6'd22, 1'b1, 1'b1},
        '{lca_pkg::OP_STEP,   5'd9,  6'd21, 1'b0, 1'b0},
        '{lca_pkg::OP_READ,   5'd10, 6'd20, 1'b0, 1'b0},
        '{lca_pkg::OP_STEP,   5'd10, 6'd21, 1'b0, 1'b0},
        '{lca_pkg::OP_TOGGLE, 5'd0,  6'd0,  1'b1, 1'b1},
        '{lca_pkg::OP_TOGGLE, 5'd0,  6'd1,  1'b1, 1'b1},
        '{lca_pkg::OP_TOGGLE, 5'd1,  6'd0,  1'b1, 1'b1},
        '{lca_pkg::OP_STEP,   5'd1,  6'd1,  1'b0, 1'b0},
        '{OP_UNUSED,          5'd0,  6'd1,  1'b0, 1'b0},
        '{lca_pkg::OP_TOGGLE, 5'd14, 6'd63, 1'b1, 1'b1},
        '{lca_pkg::OP_TOGGLE, 5'd15, 6'd63, 1'b1, 1'b1},
        '{lca_pkg::OP_TOGGLE, 5'd16, 6'd63, 1'b1, 1'b1},
        '{lca_pkg::OP_STEP,   5'd15, 6'd62, 1'b0, 1'b0},
        '{lca_pkg::OP_READ,   5'd15, 6'd0,  1'b0, 1'b0},
        '{lca_pkg::OP_STEP,   5'd31, 6'd0,  1'b0, 1'b0},
        '{lca_pkg::OP_READ,   5'd0,  6'd63, 1'b0, 1'b0}
    };

    life_cellular_automaton i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_row_index  (i_row_index),
        .i_col_index  (i_col_index),
        .o_done       (o_done),
        .o_cell_state (o_cell_state)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int live_neighbours(int r, int c);
        int n;
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < lca_pkg::GRID_HEIGHT
                        && c + dc >= 0 && c + dc < lca_pkg::GRID_WIDTH) begin
                    n += int'(life_grid[r + dr][c + dc]);
                end
            end
        end
        return n;
    endfunction

    task automatic advance_life_grid();
        logic [lca_pkg::GRID_WIDTH-1:0] next_rows [lca_pkg::GRID_HEIGHT];
        int                             n;
        for (int r = 0; r < lca_pkg::GRID_HEIGHT; r++) begin
            for (int c = 0; c < lca_pkg::GRID_WIDTH; c++) begin
                n = live_neighbours(r, c);
                next_rows[r][c] = life_grid[r][c] ? (n == 2 || n == 3) : (n == 3);
            end
        end
        life_grid = next_rows;
    endtask

    task automatic predict_cell(input logic [lca_pkg::OP_W-1:0] op, input int row,
                                input int col, output logic cell_val);
        logic on_grid;
        on_grid = row < lca_pkg::GRID_HEIGHT && col < lca_pkg::GRID_WIDTH;
        case (op)
            lca_pkg::OP_TOGGLE: begin
                if (on_grid) life_grid[row][col] = ~life_grid[row][col];
            end
            lca_pkg::OP_STEP: begin
                advance_life_grid();
            end
            default: begin
            end
        endcase
        cell_val = on_grid ? life_grid[row][col] : 1'b0;
    endtask

    task automatic report_mismatch(input string what, input int seq, input logic got,
                                   input logic want);
        $display("MISMATCH %s, request %0d: cell_state %0b, expected %0b", what, seq, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_cell_expect exp_entry;
        logic         cell_val;
        if (i_rst_n) begin
            if (o_done) begin
                if (cell_expect_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", -1, o_cell_state, 1'bx);
                end else begin
                    exp_entry = cell_expect_q.pop_front();
                    checked_count++;
                    if (o_cell_state !== exp_entry.predicted) begin
                        report_mismatch("predicted cell", exp_entry.seq, o_cell_state,
                                        exp_entry.predicted);
                    end
                    if (exp_entry.pinned && o_cell_state !== exp_entry.pin_state) begin
                        report_mismatch("scripted cell", exp_entry.seq, o_cell_state,
                                        exp_entry.pin_state);
                    end
                end
            end
            if (start && !busy) begin
                predict_cell(i_op, int'(i_row_index), int'(i_col_index), cell_val);
                if (i_op == lca_pkg::OP_STEP) steps_seen++;
                exp_entry.predicted = cell_val;
                exp_entry.pinned    = pin_check;
                exp_entry.pin_state = pin_state;
                exp_entry.seq       = accepted_count;
                cell_expect_q.push_back(exp_entry);
                accepted_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int near_coord(int centre, int max_val);
        int v;
        v = centre + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > max_val) v = max_val;
        return v;
    endfunction

    function automatic int edge_biased(int max_val);
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? max_val : 0;
        return $urandom_range(0, max_val);
    endfunction

    task automatic issue_request(input logic [lca_pkg::OP_W-1:0] op, input int row,
                                 input int col, input logic pinned,
                                 input logic pinned_state, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_op        <= op;
        i_row_index <= lca_pkg::ROW_IDX_W'(row);
        i_col_index <= lca_pkg::COL_IDX_W'(col);
        pin_check   <= pinned;
        pin_state   <= pinned_state;
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        int                          fr;
        int                          fc;
        int                          burst_len;
        logic                        quiet;
        logic [lca_pkg::OP_W-1:0]    rd_op;

        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_op           = lca_pkg::OP_READ;
        i_row_index    = '0;
        i_col_index    = '0;
        pin_check      = 1'b0;
        pin_state      = 1'b0;
        mismatch_count = 0;
        accepted_count = 0;
        checked_count  = 0;
        steps_seen     = 0;
        cycle_count    = 0;
        random_sent    = 0;
        for (int r = 0; r < lca_pkg::GRID_HEIGHT; r++) life_grid[r] = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_script[k]) begin
            issue_request(directed_script[k].op, int'(directed_script[k].row),
                          int'(directed_script[k].col), directed_script[k].pinned,
                          directed_script[k].pin_state, pick_gap());
        end

        while (random_sent < RANDOM_REQUESTS) begin
            quiet = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 3) != 0) begin
                fr = edge_biased(lca_pkg::GRID_HEIGHT - 1);
                fc = edge_biased(lca_pkg::GRID_WIDTH - 1);
                burst_len = $urandom_range(3, 7);
                repeat (burst_len) begin
                    issue_request(lca_pkg::OP_TOGGLE, near_coord(fr, lca_pkg::GRID_HEIGHT - 1),
                                  near_coord(fc, lca_pkg::GRID_WIDTH - 1), 1'b0, 1'b0,
                                  quiet ? 0 : pick_gap());
                    random_sent++;
                end
                burst_len = $urandom_range(1, 3);
                repeat (burst_len) begin
                    issue_request(lca_pkg::OP_STEP, near_coord(fr, lca_pkg::GRID_HEIGHT - 1),
                                  near_coord(fc, lca_pkg::GRID_WIDTH - 1), 1'b0, 1'b0,
                                  quiet ? 0 : pick_gap());
                    random_sent++;
                end
                burst_len = $urandom_range(1, 3);
                repeat (burst_len) begin
                    rd_op = ($urandom_range(0, 4) == 0) ? OP_UNUSED : lca_pkg::OP_READ;
                    issue_request(rd_op, near_coord(fr, lca_pkg::GRID_HEIGHT - 1),
                                  near_coord(fc, lca_pkg::GRID_WIDTH - 1), 1'b0, 1'b0,
                                  quiet ? 0 : pick_gap());
                    random_sent++;
                end
            end else begin
                issue_request(lca_pkg::OP_W'($urandom_range(0, 3)), $urandom_range(0, 31),
                              $urandom_range(0, 63), 1'b0, 1'b0, pick_gap());
                random_sent++;
            end
        end

        start <= 1'b0;
        while (cell_expect_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);

        foreach (cell_expect_q[k]) begin
            report_mismatch("no result arrived", cell_expect_q[k].seq, 1'bx,
                            cell_expect_q[k].predicted);
        end

        $display("Covered %0d scripted and %0d random requests, %0d generation steps;",
                 SCRIPT_LEN, random_sent, steps_seen);
        $display("%0d results checked, %0d mismatches.", checked_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
rtl/lca_pkg.sv
rtl/lca_row.sv
rtl/life_cellular_automaton.sv
rtl/lca_checker.sv
tb/tb_life_cellular_automaton.sv
